[src/svo_pkg.sv]
`default_nettype none

package svo_pkg;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    localparam logic ST_DONE      = 1'b0;
    localparam logic ST_POOL_FULL = 1'b1;

    localparam int COORD_BITS = 6;
    localparam int OUT_VALUE_BITS = 16;
    localparam int OUT_DEPTH_BITS = 3;

endpackage

`default_nettype wire

[src/svo_ifs.sv]
`default_nettype none

interface svo_req_if
    import svo_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    operation;
    logic [COORD_BITS-1:0]   x_coord;
    logic [COORD_BITS-1:0]   y_coord;
    logic [COORD_BITS-1:0]   z_coord;
    logic [OUT_VALUE_BITS-1:0] new_value;

    modport source (output valid, operation, x_coord, y_coord, z_coord, new_value,
                    input ready);
    modport sink   (input valid, operation, x_coord, y_coord, z_coord, new_value,
                    output ready);
endinterface

interface svo_rsp_if
    import svo_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [OUT_VALUE_BITS-1:0] found_value;
    logic [OUT_DEPTH_BITS-1:0] found_depth;
    logic                      status;

    modport source (output valid, found_value, found_depth, status, input ready);
    modport sink   (input valid, found_value, found_depth, status, output ready);
endinterface

`default_nettype wire

[src/sparse_voxel_octree_store_unit.sv]
// Sparse voxel octree store: get or set one voxel of a cube of 2^TREE_DEPTH
// voxels per side, held as a pool of 8-entry chunks in one node memory.
// Channels: req (operation, x/y/z_coord, new_value) and rsp (found_value,
// found_depth, status), both valid/ready; a transaction moves on valid & ready.
// One request is in work at a time. req.ready is high while the walker is
// idle, also while an earlier response still waits on rsp.
// Steps per request, one node memory access per cycle, read data registered:
//   get: a read and a wait per level walked, then the finish state.
//   set: a read and a wait per level walked, then per split level a chunk
//   take (with a free stack read when the chunk comes off the free stack),
//   8-entry fill and link, the leaf write, then per merge level an 8-entry
//   uniformity scan and the parent write, then the finish state.
// Reset: root chunk reads as eight zero leaves, free stack empty, chunk 1 is
// the next fresh chunk. No clearing pass is needed.
// A stalled rsp holds the finished response; a following request may be
// accepted and worked, and waits at its end until the response is taken.
`default_nettype none

module sparse_voxel_octree_store_unit
    import svo_pkg::*;
#(
    parameter int TREE_DEPTH  = 6,
    parameter int POOL_CHUNKS = 4096,
    parameter int VALUE_BITS  = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    svo_req_if.sink     req,
    svo_rsp_if.source   rsp
);

    localparam int CHUNK_W = $clog2(POOL_CHUNKS);
    localparam int ADDR_W  = CHUNK_W + 3;
    localparam int PAY_W   = (VALUE_BITS > CHUNK_W) ? VALUE_BITS : CHUNK_W;
    localparam int ENTRY_W = PAY_W + 1;
    localparam int LVL_W   = (TREE_DEPTH > 1) ? $clog2(TREE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(POOL_CHUNKS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_RDW, S_TAKE, S_TAKEW, S_FILL, S_LINK,
        S_LEAF, S_SCAN, S_FREE, S_FIN
    } state_t;

    function automatic logic [2:0] oct_at(input logic [COORD_BITS-1:0] x,
                                          input logic [COORD_BITS-1:0] y,
                                          input logic [COORD_BITS-1:0] z,
                                          input int lvl);
        int sh;
        sh = TREE_DEPTH - 1 - lvl;
        if (sh < 0 || sh >= COORD_BITS)
        begin
            return 3'd0;
        end
        return {z[sh], y[sh], x[sh]};
    endfunction

    state_t                  state_reg, state_next;
    logic                    op_reg, op_next;
    logic [COORD_BITS-1:0]   x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [VALUE_BITS-1:0]   v_reg, v_next, old_reg, old_next;
    logic [LVL_W-1:0]        lvl_reg, lvl_next;
    logic [CHUNK_W-1:0]      chunk_reg, chunk_next, c_reg, c_next;
    logic [3:0]              cnt_reg, cnt_next;
    logic [ADDR_W-1:0]       path_reg [TREE_DEPTH];
    logic [ADDR_W-1:0]       path_next [TREE_DEPTH];
    logic [CNT_W-1:0]        free_cnt_reg, free_cnt_next, fresh_reg, fresh_next;
    logic [7:0]              root_vld_reg, root_vld_next;
    logic                    rd_zero_reg, rd_zero_next;
    logic [OUT_VALUE_BITS-1:0] res_value_reg, res_value_next;
    logic [OUT_DEPTH_BITS-1:0] res_depth_reg, res_depth_next;
    logic                    res_status_reg, res_status_next;
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_VALUE_BITS-1:0] out_value_reg, out_value_next;
    logic [OUT_DEPTH_BITS-1:0] out_depth_reg, out_depth_next;
    logic                    out_status_reg, out_status_next;

    logic                    n_we;
    logic [ADDR_W-1:0]       n_addr;
    logic [ENTRY_W-1:0]      n_wdata, n_rdata;
    logic                    f_we;
    logic [CHUNK_W-1:0]      f_addr, f_wdata, f_rdata;

    logic [ENTRY_W-1:0]      entry;
    logic [ENTRY_W-1:0]      leaf_v;
    logic [CHUNK_W-1:0]      scan_chunk;
    logic [CNT_W:0]          need_w, avail_w;
    logic [CNT_W-1:0]        fresh_left;
    logic                    deep;

    svo_ram #(.WIDTH(ENTRY_W), .DEPTH(POOL_CHUNKS * 8)) u_node_ram (
        .clk   (clk),
        .we    (n_we),
        .addr  (n_addr),
        .wdata (n_wdata),
        .rdata (n_rdata)
    );

    svo_ram #(.WIDTH(CHUNK_W), .DEPTH(POOL_CHUNKS)) u_free_ram (
        .clk   (clk),
        .we    (f_we),
        .addr  (f_addr),
        .wdata (f_wdata),
        .rdata (f_rdata)
    );

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.found_value = out_value_reg;
    assign rsp.found_depth = out_depth_reg;
    assign rsp.status      = out_status_reg;

    always_comb
    begin
        entry      = rd_zero_reg ? '0 : n_rdata;
        leaf_v     = {1'b0, PAY_W'(v_reg)};
        scan_chunk = path_reg[lvl_reg][ADDR_W-1:3];
        deep       = (int'(lvl_reg) == TREE_DEPTH - 1);
        fresh_left = (fresh_reg < CNT_W'(POOL_CHUNKS)) ? CNT_W'(POOL_CHUNKS) - fresh_reg
                                                       : '0;
        need_w     = (CNT_W+1)'(TREE_DEPTH - 1 - int'(lvl_reg));
        avail_w    = {1'b0, free_cnt_reg} + {1'b0, fresh_left};

        state_next      = state_reg;
        op_next         = op_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        z_next          = z_reg;
        v_next          = v_reg;
        old_next        = old_reg;
        lvl_next        = lvl_reg;
        chunk_next      = chunk_reg;
        c_next          = c_reg;
        cnt_next        = cnt_reg;
        path_next       = path_reg;
        free_cnt_next   = free_cnt_reg;
        fresh_next      = fresh_reg;
        root_vld_next   = root_vld_reg;
        rd_zero_next    = 1'b0;
        res_value_next  = res_value_reg;
        res_depth_next  = res_depth_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_value_next  = out_value_reg;
        out_depth_next  = out_depth_reg;
        out_status_next = out_status_reg;

        n_we    = 1'b0;
        n_addr  = '0;
        n_wdata = '0;
        f_we    = 1'b0;
        f_addr  = '0;
        f_wdata = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next         = req.operation;
                    x_next          = req.x_coord;
                    y_next          = req.y_coord;
                    z_next          = req.z_coord;
                    v_next          = VALUE_BITS'(req.new_value);
                    lvl_next        = '0;
                    chunk_next      = '0;
                    res_value_next  = '0;
                    res_depth_next  = '0;
                    res_status_next = ST_DONE;
                    state_next      = S_RD;
                end
            end
            S_RD:
            begin
                n_addr              = {chunk_reg, oct_at(x_reg, y_reg, z_reg, int'(lvl_reg))};
                path_next[lvl_reg]  = n_addr;
                rd_zero_next        = (chunk_reg == '0) && !root_vld_reg[n_addr[2:0]];
                state_next          = S_RDW;
            end
            S_RDW:
            begin
                if (entry[PAY_W] && !deep)
                begin
                    chunk_next = entry[CHUNK_W-1:0];
                    lvl_next   = lvl_reg + 1'b1;
                    state_next = S_RD;
                end
                else if (op_reg == OP_GET)
                begin
                    res_value_next = OUT_VALUE_BITS'(entry[VALUE_BITS-1:0]);
                    res_depth_next = OUT_DEPTH_BITS'(lvl_reg);
                    state_next     = S_FIN;
                end
                else if (deep)
                begin
                    state_next = S_LEAF;
                end
                else if (entry[VALUE_BITS-1:0] == v_reg)
                begin
                    state_next = S_FIN;
                end
                else if (need_w > avail_w)
                begin
                    res_status_next = ST_POOL_FULL;
                    state_next      = S_FIN;
                end
                else
                begin
                    old_next   = entry[VALUE_BITS-1:0];
                    state_next = S_TAKE;
                end
            end
            S_TAKE:
            begin
                cnt_next = '0;
                if (free_cnt_reg != '0)
                begin
                    f_addr     = CHUNK_W'(free_cnt_reg - 1'b1);
                    state_next = S_TAKEW;
                end
                else
                begin
                    c_next     = CHUNK_W'(fresh_reg);
                    fresh_next = fresh_reg + 1'b1;
                    state_next = S_FILL;
                end
            end
            S_TAKEW:
            begin
                c_next        = f_rdata;
                free_cnt_next = free_cnt_reg - 1'b1;
                state_next    = S_FILL;
            end
            S_FILL:
            begin
                n_we     = 1'b1;
                n_addr   = {c_reg, cnt_reg[2:0]};
                n_wdata  = {1'b0, PAY_W'(old_reg)};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 4'd7)
                begin
                    state_next = S_LINK;
                end
            end
            S_LINK:
            begin
                n_we    = 1'b1;
                n_addr  = path_reg[lvl_reg];
                n_wdata = {1'b1, PAY_W'(c_reg)};
                if (n_addr[ADDR_W-1:3] == '0)
                begin
                    root_vld_next[n_addr[2:0]] = 1'b1;
                end
                path_next[LVL_W'(int'(lvl_reg) + 1)] =
                    {c_reg, oct_at(x_reg, y_reg, z_reg, int'(lvl_reg) + 1)};
                lvl_next   = lvl_reg + 1'b1;
                state_next = (int'(lvl_reg) + 1 == TREE_DEPTH - 1) ? S_LEAF : S_TAKE;
            end
            S_LEAF:
            begin
                n_we    = 1'b1;
                n_addr  = path_reg[TREE_DEPTH-1];
                n_wdata = leaf_v;
                if (n_addr[ADDR_W-1:3] == '0)
                begin
                    root_vld_next[n_addr[2:0]] = 1'b1;
                end
                lvl_next   = LVL_W'(TREE_DEPTH - 1);
                cnt_next   = '0;
                state_next = (TREE_DEPTH == 1) ? S_FIN : S_SCAN;
            end
            S_SCAN:
            begin
                n_addr   = {scan_chunk, cnt_reg[2:0]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg != '0 && n_rdata != leaf_v)
                begin
                    state_next = S_FIN;
                end
                else if (cnt_reg == 4'd8)
                begin
                    state_next = S_FREE;
                end
            end
            S_FREE:
            begin
                if (free_cnt_reg < CNT_W'(POOL_CHUNKS))
                begin
                    f_we          = 1'b1;
                    f_addr        = CHUNK_W'(free_cnt_reg);
                    f_wdata       = scan_chunk;
                    free_cnt_next = free_cnt_reg + 1'b1;
                end
                n_we    = 1'b1;
                n_addr  = path_reg[LVL_W'(int'(lvl_reg) - 1)];
                n_wdata = leaf_v;
                if (n_addr[ADDR_W-1:3] == '0)
                begin
                    root_vld_next[n_addr[2:0]] = 1'b1;
                end
                lvl_next   = lvl_reg - 1'b1;
                cnt_next   = '0;
                state_next = (int'(lvl_reg) == 1) ? S_FIN : S_SCAN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value_reg;
                    out_depth_next  = res_depth_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_cnt_reg  <= '0;
            fresh_reg     <= CNT_W'(1);
            root_vld_reg  <= '0;
            rd_zero_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_cnt_reg  <= free_cnt_next;
            fresh_reg     <= fresh_next;
            root_vld_reg  <= root_vld_next;
            rd_zero_reg   <= rd_zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        z_reg          <= z_next;
        v_reg          <= v_next;
        old_reg        <= old_next;
        lvl_reg        <= lvl_next;
        chunk_reg      <= chunk_next;
        c_reg          <= c_next;
        cnt_reg        <= cnt_next;
        path_reg       <= path_next;
        res_value_reg  <= res_value_next;
        res_depth_reg  <= res_depth_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_depth_reg  <= out_depth_next;
        out_status_reg <= out_status_next;
    end

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_cnt_reg <= CNT_W'(POOL_CHUNKS))
        else $error("free stack count beyond pool size");

    a_no_root_fill: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FILL |-> c_reg != '0)
        else $error("split filling the root chunk");

    a_fresh_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg != '0)
        else $error("fresh chunk pointer at root");

    a_accept_walk: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg == S_RD)
        else $error("accepted transaction did not start a walk");

endmodule

`default_nettype wire

[src/svo_ram.sv]
`default_nettype none

module svo_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 32768
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire
